### rtl/tterm_pkg.sv
// ----------------------------------------------------------------------------
// tterm_pkg
// Shared types, codes and constants of the text terminal cell engine.
// ----------------------------------------------------------------------------
package tterm_pkg;

  // Default geometry of the cell ring
  localparam int DEF_RING_ROWS   = 512;
  localparam int DEF_MAX_COLUMNS = 256;

  // Register reset values
  localparam logic [23:0] RST_TEXT_COLOR = 24'h0B6623;
  localparam logic [23:0] RST_BACK_COLOR = 24'hFFFFFF;
  localparam logic [8:0]  RST_COLUMNS    = 9'd80;
  localparam logic [8:0]  RST_ROWS       = 9'd25;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEXT_COLOR = 2'd0;
  localparam logic [1:0] CFG_BACK_COLOR = 2'd1;
  localparam logic [1:0] CFG_COLUMNS    = 2'd2;
  localparam logic [1:0] CFG_ROWS       = 2'd3;

  // Commands
  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Codepoints of interest
  localparam logic [20:0] CH_BS     = 21'h08;
  localparam logic [20:0] CH_LF     = 21'h0A;
  localparam logic [20:0] CH_CR     = 21'h0D;
  localparam logic [20:0] CH_ESC    = 21'h1B;
  localparam logic [20:0] CH_SPACE  = 21'h20;
  localparam logic [20:0] CH_ZERO   = 21'h30;
  localparam logic [20:0] CH_TWO    = 21'h32;
  localparam logic [20:0] CH_SEVEN  = 21'h37;
  localparam logic [20:0] CH_J      = 21'h4A;
  localparam logic [20:0] CH_LBRACK = 21'h5B;
  localparam logic [20:0] CH_M      = 21'h6D;

  // Escape decoder phases
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_SEEN = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;
  localparam logic [1:0] PH_SGR  = 2'd3;

  // Escape parameter codes
  localparam logic [1:0] ARG_NONE  = 2'd0;
  localparam logic [1:0] ARG_ZERO  = 2'd1;
  localparam logic [1:0] ARG_SEVEN = 2'd2;
  localparam logic [1:0] ARG_TWO   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [20:0] char_code;
    logic [7:0]  target_row;
    logic [7:0]  target_column;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        scrolled;
    logic        screen_cleared;
    logic        cell_written;
    logic [7:0]  cell_row;
    logic [7:0]  cell_column;
    logic [20:0] cell_char;
    logic [23:0] cell_fore;
    logic [23:0] cell_back;
    logic [7:0]  cursor_screen_row;
    logic [8:0]  cursor_screen_column;
    logic        inverse_on;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // capture input word
    logic exec;        // decode and apply the item
    logic write_cell;  // deferred cell write after a wrap
    logic sweep;       // blank one cell of the sweep
    logic finish;      // load result word (read data or plain)
    logic from_read;   // result carries read data
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic go_full;
    logic go_row;
    logic go_write;
    logic go_read;
    logic pend_write;
    logic col_last;
    logic row_last;
  } stat_t;

endpackage

### rtl/text_terminal_cell_engine.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_engine
// Text terminal core over a ring of character cells, with one result per word.
// ----------------------------------------------------------------------------
// Each input word (put, move or read) gives exactly one result word. A word is
// accepted in S_IDLE; S_EXEC then decodes it and performs the single cell
// write or issues the cell read (a read passes on through S_RDATA for the
// registered memory data, an auto-wrap without scroll through S_WRITE for the
// deferred write). A scroll blanks the new bottom ring row one cell per cycle
// and ESC [ 2 J blanks the whole ring, both limited by the single write port
// of the cell memory. After reset the same full clearing pass runs before the
// first word is taken; configuration writes are taken at any time. A finished
// result waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine
  import tterm_pkg::*;
#(
  parameter int RING_ROWS   = DEF_RING_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  ctl_t  ctl;
  stat_t st;

  // registers accept a write every cycle
  assign cfg_ready = 1'b1;

  tterm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  tterm_dpath #(
    .RING_ROWS   (RING_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .st        (st)
  );

endmodule

### rtl/tterm_ctrl.sv
// ----------------------------------------------------------------------------
// tterm_ctrl
// Sequencer: accepts words, steps execution, memory sweeps and result loads.
// ----------------------------------------------------------------------------
module tterm_ctrl
  import tterm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output ctl_t  ctl
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_FULL  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_RDATA = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_INIT: begin
        ctl.sweep = 1'b1;
        if (st.col_last && st.row_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.take = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.out_free) begin
          ctl.exec = 1'b1;
          if (st.go_full)       state_next = S_FULL;
          else if (st.go_row)   state_next = S_ROW;
          else if (st.go_write) state_next = S_WRITE;
          else if (st.go_read)  state_next = S_RDATA;
          else                  state_next = S_IDLE;
        end
      end
      S_ROW: begin
        ctl.sweep = 1'b1;
        if (st.col_last) state_next = st.pend_write ? S_WRITE : S_DONE;
      end
      S_FULL: begin
        ctl.sweep = 1'b1;
        if (st.col_last && st.row_last) state_next = S_DONE;
      end
      S_WRITE: begin
        if (st.out_free) begin
          ctl.write_cell = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RDATA: begin
        if (st.out_free) begin
          ctl.finish    = 1'b1;
          ctl.from_read = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

endmodule

### rtl/tterm_dpath.sv
// ----------------------------------------------------------------------------
// tterm_dpath
// Cell memory, cursor and escape state, configuration and result register.
// ----------------------------------------------------------------------------
module tterm_dpath
  import tterm_pkg::*;
#(
  parameter int RING_ROWS   = DEF_RING_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic        clk,
  input  logic        rst,
  input  in_t         in_data,
  output out_t        out_data,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  ctl_t        ctl,
  output stat_t       st
);

  localparam int RW    = $clog2(RING_ROWS);
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CLW   = $clog2(MAX_COLUMNS + 1);
  localparam int CVW   = (CLW > 9) ? CLW : 9;
  localparam int XW    = ((RW > 9) ? RW : 9) + 1;
  localparam int CELLS = RING_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RCAP  = (RING_ROWS < 256) ? RING_ROWS : 256;
  localparam int MW    = 69;

  // configuration
  logic [23:0] text_color, back_color;
  logic [8:0]  columns_shown, rows_shown;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color    <= RST_TEXT_COLOR;
      back_color    <= RST_BACK_COLOR;
      columns_shown <= RST_COLUMNS;
      rows_shown    <= RST_ROWS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEXT_COLOR: text_color    <= cfg_data;
        CFG_BACK_COLOR: back_color    <= cfg_data;
        CFG_COLUMNS:    columns_shown <= cfg_data[8:0];
        CFG_ROWS:       rows_shown    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CVW-1:0] cols_ext;
  logic [CLW-1:0] effc;
  logic [8:0]     effr;

  assign cols_ext = CVW'(columns_shown);
  assign effc = (columns_shown == 9'd0) ? CLW'(1) :
                (cols_ext > CVW'(MAX_COLUMNS)) ? CLW'(MAX_COLUMNS) : CLW'(columns_shown);
  assign effr = (rows_shown == 9'd0) ? 9'd1 :
                (rows_shown > 9'(RCAP)) ? 9'(RCAP) : rows_shown;

  function automatic logic [RW-1:0] ring_add(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [XW-1:0] s;
    s = a + b;
    if (s >= XW'(RING_ROWS)) s = s - XW'(RING_ROWS);
    return RW'(s);
  endfunction

  function automatic logic [RW-1:0] scr_row(input logic [RW-1:0] r, input logic [RW-1:0] t);
    logic [XW-1:0] d;
    if (r >= t) d = XW'(r) - XW'(t);
    else        d = XW'(r) + XW'(RING_ROWS) - XW'(t);
    return RW'(d);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_COLUMNS) + AW'(c);
  endfunction

  // item and terminal state
  in_t            item;
  logic [RW-1:0]  top, cur_row;
  logic [CLW-1:0] cur_col;
  logic [1:0]     phase, arg;
  logic           inv;
  logic           pend_scr, pend_clr, pend_wr;

  logic [RW-1:0]  top_next, cur_row_next;
  logic [CLW-1:0] cur_col_next;
  logic [1:0]     phase_next, arg_next;
  logic           inv_next;

  // decode results
  logic acc, fin_exec, go_full, go_row, go_write, go_read, wr_now;

  // newline arithmetic
  logic [RW-1:0]  scr_cur, top_inc, nl_row, cur_inc, rd_ring;
  logic [XW-1:0]  scr_ext, bot_off;
  logic           nl_scroll, in_range;
  logic [20:0]    cp;

  assign cp       = item.char_code;
  assign scr_cur  = scr_row(cur_row, top);
  assign scr_ext  = XW'(scr_cur);
  assign bot_off  = XW'(effr) - XW'(1);
  assign nl_scroll = (scr_ext >= bot_off);
  assign top_inc  = ring_add(XW'(top), XW'(1));
  assign nl_row   = ring_add(XW'(top_inc), bot_off);
  assign cur_inc  = ring_add(XW'(cur_row), XW'(1));
  assign rd_ring  = ring_add(XW'(top), XW'(item.target_row));
  assign in_range = (9'(item.target_row) < effr) &&
                    (CVW'(item.target_column) < CVW'(effc));

  // item decode, applied only while executing; a deferred cell write also advances the column
  always_comb begin
    top_next     = top;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    phase_next   = phase;
    arg_next     = arg;
    inv_next     = inv;
    acc      = 1'b1;
    fin_exec = 1'b0;
    go_full  = 1'b0;
    go_row   = 1'b0;
    go_write = 1'b0;
    go_read  = 1'b0;
    wr_now   = 1'b0;
    if (ctl.exec) begin
      case (item.cmd)
        CMD_PUT: begin
          case (phase)
            PH_SEEN: begin
              phase_next = (cp == CH_LBRACK) ? PH_CSI : PH_NONE;
              fin_exec = 1'b1;
            end
            PH_CSI: begin
              fin_exec = 1'b1;
              if (cp == CH_ZERO) begin
                arg_next = ARG_ZERO;
                phase_next = PH_SGR;
              end else if (cp == CH_SEVEN) begin
                arg_next = ARG_SEVEN;
                phase_next = PH_SGR;
              end else if (cp == CH_TWO) begin
                arg_next = ARG_TWO;
              end else if (cp == CH_J && arg == ARG_TWO) begin
                top_next     = '0;
                cur_row_next = '0;
                cur_col_next = '0;
                inv_next     = 1'b0;
                phase_next   = PH_NONE;
                go_full      = 1'b1;
                fin_exec     = 1'b0;
              end else begin
                phase_next = PH_NONE;
              end
            end
            PH_SGR: begin
              if (cp == CH_M) inv_next = (arg == ARG_SEVEN);
              phase_next = PH_NONE;
              fin_exec = 1'b1;
            end
            default: begin
              if (cp == CH_ESC) begin
                phase_next = PH_SEEN;
                fin_exec = 1'b1;
              end else if (cp == CH_CR) begin
                cur_col_next = '0;
                fin_exec = 1'b1;
              end else if (cp == CH_BS) begin
                if (cur_col != '0) cur_col_next = cur_col - CLW'(1);
                fin_exec = 1'b1;
              end else if (cp == CH_LF || cur_col >= effc) begin
                // newline, either explicit or an auto-wrap before a printable
                cur_col_next = '0;
                if (nl_scroll) begin
                  top_next     = top_inc;
                  cur_row_next = nl_row;
                  go_row       = 1'b1;
                end else begin
                  cur_row_next = cur_inc;
                  if (cp == CH_LF) fin_exec = 1'b1;
                  else             go_write = 1'b1;
                end
              end else begin
                wr_now = 1'b1;
                cur_col_next = cur_col + CLW'(1);
                fin_exec = 1'b1;
              end
            end
          endcase
        end
        CMD_MOVE: begin
          fin_exec = 1'b1;
          if (!in_range) begin
            acc = 1'b0;
          end else begin
            cur_row_next = rd_ring;
            cur_col_next = CLW'(item.target_column);
          end
        end
        CMD_READ: begin
          if (!in_range) begin
            acc = 1'b0;
            fin_exec = 1'b1;
          end else begin
            go_read = 1'b1;
          end
        end
        default: fin_exec = 1'b1;
      endcase
    end
    if (ctl.write_cell) cur_col_next = cur_col + CLW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top      <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
      phase    <= PH_NONE;
      arg      <= ARG_NONE;
      inv      <= 1'b0;
      pend_scr <= 1'b0;
      pend_clr <= 1'b0;
      pend_wr  <= 1'b0;
    end else begin
      top     <= top_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      phase   <= phase_next;
      arg     <= arg_next;
      inv     <= inv_next;
      if (ctl.take) begin
        pend_scr <= 1'b0;
        pend_clr <= 1'b0;
        pend_wr  <= 1'b0;
      end else if (ctl.exec) begin
        pend_scr <= go_row;
        pend_clr <= go_full;
        pend_wr  <= go_row && (cp != CH_LF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) item <= in_data;
  end

  // sweep counters for row and full clears
  logic [RW-1:0] sw_row;
  logic [CW-1:0] sw_col;
  logic [23:0]   sw_fore, sw_back;
  logic          col_last, row_last;

  assign col_last = (sw_col == CW'(MAX_COLUMNS - 1));
  assign row_last = (sw_row == RW'(RING_ROWS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_row  <= '0;
      sw_col  <= '0;
      sw_fore <= RST_TEXT_COLOR;
      sw_back <= RST_BACK_COLOR;
    end else if (ctl.exec && (go_full || go_row)) begin
      sw_row  <= go_row ? nl_row : '0;
      sw_col  <= '0;
      sw_fore <= text_color;
      sw_back <= back_color;
    end else if (ctl.sweep) begin
      if (col_last) begin
        sw_col <= '0;
        sw_row <= row_last ? '0 : sw_row + RW'(1);
      end else begin
        sw_col <= sw_col + CW'(1);
      end
    end
  end

  // cell memory: one write and one registered read port
  logic [MW-1:0] mem [CELLS];
  logic [MW-1:0] rd_q, cell_wdata;
  logic [23:0]   cell_fore, cell_back;
  logic          cell_we;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata;

  assign cell_we    = wr_now || ctl.write_cell;
  assign cell_fore  = inv ? back_color : text_color;
  assign cell_back  = inv ? text_color : back_color;
  assign cell_wdata = {cp, cell_fore, cell_back};
  assign waddr = ctl.sweep ? cell_addr(sw_row, sw_col)
                           : cell_addr(cur_row, cur_col[CW-1:0]);
  assign wdata = ctl.sweep ? {CH_SPACE, sw_fore, sw_back} : cell_wdata;

  always_ff @(posedge clk) begin
    if (ctl.sweep || cell_we) mem[waddr] <= wdata;
    if (ctl.exec && go_read) rd_q <= mem[cell_addr(rd_ring, CW'(item.target_column))];
  end

  // result word
  logic finish;
  out_t res;

  assign finish = (ctl.exec && fin_exec) || ctl.write_cell || ctl.finish;

  always_comb begin
    res = '0;
    res.accepted       = ctl.exec ? acc : 1'b1;
    res.scrolled       = pend_scr;
    res.screen_cleared = pend_clr;
    res.cell_written   = cell_we;
    if (cell_we) begin
      res.cell_row    = 8'(scr_cur);
      res.cell_column = 8'(cur_col);
      res.cell_char   = cp;
      res.cell_fore   = cell_fore;
      res.cell_back   = cell_back;
    end else if (ctl.from_read) begin
      res.cell_row    = item.target_row;
      res.cell_column = item.target_column;
      res.cell_char   = rd_q[68:48];
      res.cell_fore   = rd_q[47:24];
      res.cell_back   = rd_q[23:0];
    end
    res.cursor_screen_row    = 8'(scr_row(cur_row_next, top_next));
    res.cursor_screen_column = 9'(cur_col_next);
    res.inverse_on           = inv_next;
  end

  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (finish)    out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish) out_data <= res;
  end

  // status
  always_comb begin
    st.out_free   = !out_valid || out_ready;
    st.go_full    = go_full;
    st.go_row     = go_row;
    st.go_write   = go_write;
    st.go_read    = go_read;
    st.pend_write = pend_wr;
    st.col_last   = col_last;
    st.row_last   = row_last;
  end

endmodule

### tb/text_terminal_cell_engine_chk.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_engine_chk
// Watches the input, result and register channels of the terminal engine,
// keeps its own copy of the cell ring, cursor and escape decoder, works out
// the result of every accepted word and compares it field by field.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine_chk
  import tterm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = DEF_RING_ROWS;
  localparam int NCOLS = DEF_MAX_COLUMNS;

  // shadow registers
  logic [23:0] fg_reg, bg_reg;
  logic [8:0]  cols_reg, rows_reg;

  // shadow cell ring and terminal state
  logic [20:0] glyph_mem [NROWS*NCOLS];
  logic [23:0] fore_mem  [NROWS*NCOLS];
  logic [23:0] back_mem  [NROWS*NCOLS];
  int unsigned top_row, cur_row, cur_col;
  logic [1:0]  esc_phase, esc_arg;
  logic        inverse;
  logic        in_reset = 1'b0;

  out_t result_q [$];

  assign pending = result_q.size();

  function automatic int unsigned vis_cols();
    int unsigned c;
    c = cols_reg;
    if (c == 0) c = 1;
    if (c > NCOLS) c = NCOLS;
    return c;
  endfunction

  function automatic int unsigned vis_rows();
    int unsigned r;
    r = rows_reg;
    if (r == 0) r = 1;
    if (r > 256) r = 256;
    if (r > NROWS) r = NROWS;
    return r;
  endfunction

  function automatic int unsigned ring_to_scr(int unsigned ring);
    return (ring + NROWS - top_row) % NROWS;
  endfunction

  task automatic blank_row(int unsigned ring);
    int unsigned base;
    base = (ring % NROWS) * NCOLS;
    for (int c = 0; c < NCOLS; c++) begin
      glyph_mem[base+c] = CH_SPACE;
      fore_mem[base+c]  = fg_reg;
      back_mem[base+c]  = bg_reg;
    end
  endtask

  task automatic wipe_screen();
    top_row   = 0;
    cur_row   = 0;
    cur_col   = 0;
    inverse   = 1'b0;
    esc_phase = PH_NONE;
    for (int r = 0; r < NROWS; r++) blank_row(r);
  endtask

  // newline; returns 1 when the ring scrolled
  task automatic line_feed(output logic scr);
    int unsigned rows;
    rows    = vis_rows();
    cur_col = 0;
    if (ring_to_scr(cur_row) >= rows - 1) begin
      top_row = (top_row + 1) % NROWS;
      cur_row = (top_row + rows - 1) % NROWS;
      blank_row(cur_row);
      scr = 1'b1;
    end else begin
      cur_row = (cur_row + 1) % NROWS;
      scr = 1'b0;
    end
  endtask

  // apply one word to the shadow state and build its result word
  task automatic terminal_step(input in_t w, output out_t r);
    int unsigned addr, ring;
    logic scr;
    r = '0;
    r.accepted = 1'b1;
    if (w.cmd == CMD_PUT) begin
      if (esc_phase == PH_SEEN) begin
        esc_phase = (w.char_code == CH_LBRACK) ? PH_CSI : PH_NONE;
      end else if (esc_phase == PH_CSI) begin
        if (w.char_code == CH_ZERO) begin
          esc_arg = ARG_ZERO;
          esc_phase = PH_SGR;
        end else if (w.char_code == CH_SEVEN) begin
          esc_arg = ARG_SEVEN;
          esc_phase = PH_SGR;
        end else if (w.char_code == CH_TWO) begin
          esc_arg = ARG_TWO;
        end else if (w.char_code == CH_J && esc_arg == ARG_TWO) begin
          wipe_screen();
          r.screen_cleared = 1'b1;
        end else begin
          esc_phase = PH_NONE;
        end
      end else if (esc_phase == PH_SGR) begin
        if (w.char_code == CH_M) inverse = (esc_arg == ARG_SEVEN);
        esc_phase = PH_NONE;
      end else if (w.char_code == CH_ESC) begin
        esc_phase = PH_SEEN;
      end else if (w.char_code == CH_CR) begin
        cur_col = 0;
      end else if (w.char_code == CH_BS) begin
        if (cur_col > 0) cur_col--;
      end else if (w.char_code == CH_LF) begin
        line_feed(scr);
        r.scrolled = scr;
      end else begin
        // printable: wrap first when the cursor sits past the last column
        if (cur_col >= vis_cols()) begin
          line_feed(scr);
          r.scrolled = scr;
        end
        addr = (cur_row % NROWS) * NCOLS + (cur_col % NCOLS);
        r.cell_fore = inverse ? bg_reg : fg_reg;
        r.cell_back = inverse ? fg_reg : bg_reg;
        glyph_mem[addr] = w.char_code;
        fore_mem[addr]  = r.cell_fore;
        back_mem[addr]  = r.cell_back;
        r.cell_written  = 1'b1;
        r.cell_row      = 8'(ring_to_scr(cur_row));
        r.cell_column   = 8'(cur_col);
        r.cell_char     = w.char_code;
        cur_col++;
      end
    end else if (w.cmd == CMD_MOVE || w.cmd == CMD_READ) begin
      if (w.target_row >= vis_rows() || w.target_column >= vis_cols()) begin
        r.accepted = 1'b0;
      end else begin
        ring = (top_row + w.target_row) % NROWS;
        if (w.cmd == CMD_MOVE) begin
          cur_row = ring;
          cur_col = w.target_column;
        end else begin
          addr = ring * NCOLS + w.target_column;
          r.cell_row    = w.target_row;
          r.cell_column = w.target_column;
          r.cell_char   = glyph_mem[addr];
          r.cell_fore   = fore_mem[addr];
          r.cell_back   = back_mem[addr];
        end
      end
    end
    r.cursor_screen_row    = 8'(ring_to_scr(cur_row));
    r.cursor_screen_column = 9'(cur_col);
    r.inverse_on           = inverse;
  endtask

  task automatic field_check(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_t e, r;
    if (rst) begin
      // rebuild the reset picture once per reset pulse
      if (!in_reset) begin
        errors   = 0;
        fg_reg   = RST_TEXT_COLOR;
        bg_reg   = RST_BACK_COLOR;
        cols_reg = RST_COLUMNS;
        rows_reg = RST_ROWS;
        esc_arg  = ARG_NONE;
        wipe_screen();
        result_q.delete();
      end
      in_reset = 1'b1;
    end else begin
      in_reset = 1'b0;
      // result words
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result word %h with none expected", $realtime, out_data);
        end else begin
          e = result_q.pop_front();
          field_check("accepted",       e.accepted,             out_data.accepted);
          field_check("scrolled",       e.scrolled,             out_data.scrolled);
          field_check("screen_cleared", e.screen_cleared,       out_data.screen_cleared);
          field_check("cell_written",   e.cell_written,         out_data.cell_written);
          field_check("cell_row",       e.cell_row,             out_data.cell_row);
          field_check("cell_column",    e.cell_column,          out_data.cell_column);
          field_check("cell_char",      e.cell_char,            out_data.cell_char);
          field_check("cell_fore",      e.cell_fore,            out_data.cell_fore);
          field_check("cell_back",      e.cell_back,            out_data.cell_back);
          field_check("cursor_row",     e.cursor_screen_row,    out_data.cursor_screen_row);
          field_check("cursor_column",  e.cursor_screen_column,
                      out_data.cursor_screen_column);
          field_check("inverse_on",     e.inverse_on,           out_data.inverse_on);
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXT_COLOR: fg_reg   = cfg_data;
          CFG_BACK_COLOR: bg_reg   = cfg_data;
          CFG_COLUMNS:    cols_reg = cfg_data[8:0];
          CFG_ROWS:       rows_reg = cfg_data[8:0];
          default: ;
        endcase
      end
      // input words
      if (in_valid && in_ready) begin
        terminal_step(in_data, r);
        result_q.push_back(r);
      end
    end
  end

endmodule

### tb/text_terminal_cell_engine_tb.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_engine_tb
// Drives put, move and read words and register writes into the terminal
// engine over several screen geometries, with random gaps on both channels
// and one long result hold-off; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module text_terminal_cell_engine_tb;
  import tterm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst;
  logic        in_valid, in_ready;
  in_t         in_data;
  logic        out_valid, out_ready;
  out_t        out_data;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  int          errors, pending;

  logic        no_gaps;   // stretch with no idling on either side
  logic        squeeze;   // request a long result hold-off
  int          clears;    // full clears sent so far
  int unsigned cols_now, rows_now;

  text_terminal_cell_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  text_terminal_cell_engine_chk CHK (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

  function automatic int gap_len();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, one long hold when asked
  initial begin
    int g;
    logic held;
    out_ready = 1'b0;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (squeeze && !held) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        held = 1'b1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [1:0] c, logic [20:0] ch, logic [7:0] r, logic [7:0] col);
    int g;
    in_t w;
    w = '{cmd: c, char_code: ch, target_row: r, target_column: col};
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_char(logic [20:0] ch);
    send_word(CMD_PUT, ch, $urandom(), $urandom());
  endtask

  task automatic escape_seq(logic [20:0] a, logic [20:0] b);
    put_char(CH_ESC);
    put_char(CH_LBRACK);
    put_char(a);
    put_char(b);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_geometry(logic [23:0] fg, logic [23:0] bg, logic [8:0] c, logic [8:0] r);
    drain();
    reg_write(CFG_TEXT_COLOR, fg);
    reg_write(CFG_BACK_COLOR, bg);
    reg_write(CFG_COLUMNS, {15'd0, c});
    reg_write(CFG_ROWS, {15'd0, r});
    cols_now = (c == 0) ? 1 : (c > 256) ? 256 : c;
    rows_now = (r == 0) ? 1 : (r > 256) ? 256 : r;
  endtask

  function automatic logic [20:0] text_char();
    logic [20:0] ch;
    if ($urandom_range(0, 3) == 0) ch = $urandom_range(21'h20, 21'h10FFFF);
    else ch = $urandom_range(21'h21, 21'h7E);
    if (ch == CH_ESC) ch = CH_SPACE;
    return ch;
  endfunction

  // one random transaction, mostly well formed
  task automatic random_item();
    int p;
    logic [20:0] a, b;
    p = $urandom_range(0, 99);
    if (p < 45) begin
      put_char(text_char());
    end else if (p < 55) begin
      put_char(CH_LF);
    end else if (p < 60) begin
      put_char(CH_CR);
    end else if (p < 65) begin
      put_char(CH_BS);
    end else if (p < 75) begin
      // attribute sequence with random content, stray parameters included
      case ($urandom_range(0, 3))
        0: a = CH_ZERO;
        1: a = CH_SEVEN;
        2: a = CH_TWO;
        default: a = $urandom_range(21'h20, 21'h7E);
      endcase
      b = ($urandom_range(0, 3) != 0) ? CH_M : $urandom_range(21'h20, 21'h7E);
      if (a == CH_J) a = CH_M;
      if (b == CH_J) b = CH_M;
      escape_seq(a, b);
    end else if (p < 85) begin
      if ($urandom_range(0, 4) == 0)
        send_word(CMD_MOVE, $urandom(), $urandom(), $urandom());
      else
        send_word(CMD_MOVE, $urandom(), $urandom_range(0, rows_now-1),
                  $urandom_range(0, cols_now-1));
    end else if (p < 97) begin
      if ($urandom_range(0, 4) == 0)
        send_word(CMD_READ, $urandom(), $urandom(), $urandom());
      else
        send_word(CMD_READ, $urandom(), $urandom_range(0, rows_now-1),
                  $urandom_range(0, cols_now-1));
    end else if (p < 99 || clears >= 3) begin
      // noise, unused command included
      a = $urandom_range(0, 21'h10FFFF);
      if (a == CH_J) a = CH_M;
      send_word($urandom_range(0, 3), a, $urandom(), $urandom());
    end else begin
      clears++;
      escape_seq(CH_TWO, CH_J);
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TEXT_COLOR;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    squeeze   = 1'b0;
    clears    = 0;
    cols_now  = RST_COLUMNS;
    rows_now  = RST_ROWS;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: controls, attributes, clears, moves and reads at the edges
    put_char(21'h41);
    put_char(21'h10FFFF);
    put_char(21'h0);
    escape_seq(CH_SEVEN, CH_M);
    put_char(21'h42);
    escape_seq(CH_ZERO, CH_M);
    put_char(CH_BS);
    put_char(CH_CR);
    put_char(CH_BS);
    put_char(CH_LF);
    send_word(CMD_MOVE, 0, 24, 79);
    put_char(21'h43);
    put_char(21'h44);
    put_char(CH_LF);
    send_word(CMD_MOVE, 0, 25, 0);
    send_word(CMD_MOVE, 0, 0, 80);
    send_word(CMD_READ, 0, 24, 79);
    send_word(CMD_READ, 0, 255, 255);
    send_word(CMD_READ, 0, 0, 0);
    send_word(2'd3, 21'h1FFFFF, 8'hFF, 8'hFF);
    escape_seq(CH_SEVEN, CH_M);
    escape_seq(CH_TWO, CH_J);
    put_char(CH_ESC);
    put_char(CH_LBRACK);
    put_char(CH_J);
    clears = 2;

    // random phases over several geometries
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_geometry(24'h000000, 24'hFFFFFF, 9'd1, 9'd1);
        2: set_geometry(24'hFFFFFF, 24'h000000, 9'd256, 9'd256);
        3: set_geometry($urandom(), $urandom(), 9'd0, 9'd0);
        4: set_geometry($urandom(), $urandom(), 9'd511, 9'd300);
        5: set_geometry($urandom(), $urandom(), 9'd7, 9'd3);
        default: ;
      endcase
      for (int i = 0; i < 120; i++) begin
        if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (ph == 2 && i == 20) squeeze = 1'b1;
        random_item();
      end
      no_gaps = 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/tterm_pkg.sv
rtl/tterm_ctrl.sv
rtl/tterm_dpath.sv
rtl/text_terminal_cell_engine.sv
tb/text_terminal_cell_engine_chk.sv
tb/text_terminal_cell_engine_tb.sv
